FILE: src/wcc_pkg.sv
// Shared types and constants for the weighted clustering coefficient block.
package wcc_pkg;

  localparam int unsigned MAX_NODES_DEF = 1024;
  localparam int unsigned MAX_EDGES_DEF = 8192;

  localparam int unsigned OP_W   = 2;
  localparam int unsigned SLOT_W = 14;
  localparam int unsigned ID_W   = 14;
  localparam int unsigned WT_W   = 32;
  localparam int unsigned CNT_W  = 11;
  localparam int unsigned NID_W  = 10;
  localparam int unsigned COEF_W = 32;
  localparam int unsigned FRAC_SHIFT = 30;
  localparam logic [COEF_W-1:0] Q31_ONE = 32'h8000_0000;
  localparam logic [NID_W-1:0] DEG_MAX = 10'd1023;

  typedef enum logic [OP_W-1:0] {
    OP_ROW     = 2'd0,
    OP_EDGE    = 2'd1,
    OP_COMPUTE = 2'd2,
    OP_QUERY   = 2'd3
  } op_e;

  typedef enum logic {
    ALU_MUL = 1'b0,
    ALU_DIV = 1'b1
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_OUT, ST_QRY0, ST_QRY1, ST_QRY2,
    ST_SPAN0, ST_SPAN1, ST_SPAN2, ST_ARD, ST_AWT, ST_J1, ST_J2,
    ST_BRD, ST_BWT, ST_SRD, ST_SWT, ST_MUL, ST_MULW, ST_DIVW,
    ST_STORE, ST_AVGW
  } state_e;

endpackage

FILE: src/wcc_alu.sv
// Iterative shift-add multiplier and restoring divider, one bit per cycle.
module wcc_alu #(
  parameter int unsigned DVW = 90,
  parameter int unsigned DNW = 59,
  parameter int unsigned MBW = 14
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wcc_pkg::alu_req_t req_i,
  input  logic [DVW-1:0]    opa_i,
  input  logic [DNW-1:0]    opb_i,
  input  logic [MBW-1:0]    opc_i,
  output logic              busy_o,
  output logic [DVW-1:0]    res_o
);
  import wcc_pkg::*;

  localparam int unsigned CW = $clog2(DVW + 1);

  logic           busy_q, busy_d;
  alu_op_e        op_q, op_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [DVW-1:0] acc_q, acc_d;
  logic [DNW-1:0] rem_q, rem_d;
  logic [DNW-1:0] den_q, den_d;
  logic [MBW-1:0] mpl_q, mpl_d;
  logic [DNW:0]   trial;
  logic [DNW:0]   diff;

  assign trial = {rem_q, acc_q[DVW-1]};
  assign diff  = trial - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    op_d   = op_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    den_d  = den_q;
    mpl_d  = mpl_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      op_d   = req_i.op;
      rem_d  = '0;
      den_d  = opb_i;
      mpl_d  = opc_i;
      if (req_i.op == ALU_MUL) begin
        acc_d = '0;
        cnt_d = CW'(MBW);
      end else begin
        acc_d = opa_i;
        cnt_d = CW'(DVW);
      end
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) busy_d = 1'b0;
      unique case (op_q)
        ALU_MUL: begin
          if (mpl_q[0]) acc_d = acc_q + DVW'(den_q);
          den_d = {den_q[DNW-2:0], 1'b0};
          mpl_d = mpl_q >> 1;
        end
        ALU_DIV: begin
          if (!diff[DNW]) begin
            rem_d = diff[DNW-1:0];
            acc_d = {acc_q[DVW-2:0], 1'b1};
          end else begin
            rem_d = trial[DNW-1:0];
            acc_d = {acc_q[DVW-2:0], 1'b0};
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      op_q   <= ALU_MUL;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
    den_q <= den_d;
    mpl_q <= mpl_d;
  end

  assign busy_o = busy_q;
  assign res_o  = acc_q;

endmodule

FILE: src/weighted_clustering_coefficient.sv
// Weighted clustering coefficient top level: graph stores, sequencer, output register.
// Load words (row start, edge) write the stores directly; a query word reads its row bounds
// and stored coefficient. A compute word walks every node: per node it reads the row bounds,
// scans each row slot, reads each neighbor row, scans each neighbor-of-neighbor slot and the
// slots of the own row for the matching edge, then runs a multiply and a divide in the shared
// bit-serial unit; the average adds one more divide. The single read port of each store and
// the one shared multiply/divide unit set the pace of this walk.
module weighted_clustering_coefficient #(
  parameter int unsigned MAX_NODES = wcc_pkg::MAX_NODES_DEF,
  parameter int unsigned MAX_EDGES = wcc_pkg::MAX_EDGES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [wcc_pkg::CNT_W-1:0]   cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [wcc_pkg::OP_W-1:0]    op_i,
  input  logic [wcc_pkg::SLOT_W-1:0]  slot_i,
  input  logic [wcc_pkg::ID_W-1:0]    entry_value_i,
  input  logic [wcc_pkg::WT_W-1:0]    edge_weight_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        result_kind_o,
  output logic [wcc_pkg::NID_W-1:0]   node_id_o,
  output logic [wcc_pkg::NID_W-1:0]   node_degree_o,
  output logic [wcc_pkg::COEF_W-1:0]  coefficient_o,
  output logic                        error_flag_o
);
  import wcc_pkg::*;

  localparam int unsigned NAW  = $clog2(MAX_NODES + 1);
  localparam int unsigned CAW  = $clog2(MAX_NODES);
  localparam int unsigned EAW  = $clog2(MAX_EDGES);
  localparam int unsigned OW   = $clog2(MAX_EDGES + 1);
  localparam int unsigned SW   = WT_W + OW;
  localparam int unsigned DENW = SW + OW;
  localparam int unsigned SUMW = WT_W + 1 + 2 * OW;
  localparam int unsigned DVW  = SUMW + FRAC_SHIFT;
  localparam int unsigned AW   = COEF_W + NAW;

  function automatic logic [OW-1:0] clip_f(logic [ID_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    if (w > 32'(MAX_EDGES)) w = 32'(MAX_EDGES);
    return OW'(w);
  endfunction

  logic [ID_W-1:0]   rs_mem [MAX_NODES+1];
  logic [ID_W-1:0]   nb_mem [MAX_EDGES];
  logic [WT_W-1:0]   wt_mem [MAX_EDGES];
  logic [COEF_W-1:0] cf_mem [MAX_NODES];

  logic              rs_we, eg_we, cf_we;
  logic [NAW-1:0]    rs_raddr;
  logic [EAW-1:0]    eg_raddr;
  logic [ID_W-1:0]   rs_rd_q, nb_rd_q;
  logic [WT_W-1:0]   wt_rd_q;
  logic [COEF_W-1:0] cf_rd_q;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  nc_q, nc_d;
  logic [NAW-1:0]    i_q, i_d;
  logic [OW-1:0]     lo_q, lo_d, hi_q, hi_d, a_q, a_d, b_q, b_d, jhi_q, jhi_d, s_q, s_d;
  logic [OW-1:0]     clip_rd, deg_w;
  logic [ID_W-1:0]   j_q, j_d, h_q, h_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [WT_W-1:0]   wa_q, wa_d;
  logic [SW-1:0]     str_q, str_d;
  logic [SUMW-1:0]   sum_q, sum_d;
  logic [AW-1:0]     acc_q, acc_d, acc_sum;
  logic [COEF_W-1:0] coef_q, coef_d;

  logic              ov_q, ov_d, kind_q, kind_d, err_q, err_d;
  logic [NID_W-1:0]  id_q, id_d, deg_q, deg_d;
  logic [COEF_W-1:0] oc_q, oc_d;

  alu_req_t          alu_req;
  logic [DVW-1:0]    alu_a, alu_res;
  logic [DENW-1:0]   alu_b;
  logic [OW-1:0]     alu_c;
  logic              alu_busy;
  logic              accept;

  assign in_ready_o = (state_q == ST_IDLE) && !ov_q;
  assign accept     = in_valid_i && in_ready_o;
  assign rs_we = accept && (op_e'(op_i) == OP_ROW) && (32'(slot_i) <= 32'(MAX_NODES));
  assign eg_we = accept && (op_e'(op_i) == OP_EDGE) && (32'(slot_i) < 32'(MAX_EDGES));
  assign cf_we = (state_q == ST_STORE);
  assign clip_rd = clip_f(rs_rd_q);
  assign acc_sum = acc_q + AW'(coef_q);

  always_ff @(posedge clk_i) begin
    if (rs_we) rs_mem[NAW'(slot_i)] <= entry_value_i;
    rs_rd_q <= rs_mem[rs_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (eg_we) begin
      nb_mem[EAW'(slot_i)] <= entry_value_i;
      wt_mem[EAW'(slot_i)] <= edge_weight_i;
    end
    nb_rd_q <= nb_mem[eg_raddr];
    wt_rd_q <= wt_mem[eg_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cf_we) cf_mem[CAW'(i_q)] <= coef_q;
    cf_rd_q <= cf_mem[CAW'(slot_q)];
  end

  wcc_alu #(.DVW(DVW), .DNW(DENW), .MBW(OW)) u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .opa_i  (alu_a),
    .opb_i  (alu_b),
    .opc_i  (alu_c),
    .busy_o (alu_busy),
    .res_o  (alu_res)
  );

  always_comb begin
    state_d = state_q;
    nc_d = nc_q;
    i_d = i_q; lo_d = lo_q; hi_d = hi_q; a_d = a_q; b_d = b_q; jhi_d = jhi_q; s_d = s_q;
    j_d = j_q; h_d = h_q; slot_d = slot_q; wa_d = wa_q;
    str_d = str_q; sum_d = sum_q; acc_d = acc_q; coef_d = coef_q;
    ov_d = ov_q; kind_d = kind_q; err_d = err_q; id_d = id_q; deg_d = deg_q; oc_d = oc_q;
    rs_raddr = NAW'(i_q);
    eg_raddr = EAW'(a_q);
    alu_req.start = 1'b0;
    alu_req.op    = ALU_MUL;
    alu_a = {sum_q, FRAC_SHIFT'(0)};
    alu_b = DENW'(str_q);
    alu_c = hi_q - lo_q - 1'b1;
    deg_w = '0;

    if (cfg_we_i) begin
      if (32'(cfg_wdata_i) > 32'(MAX_NODES)) nc_d = CNT_W'(MAX_NODES);
      else nc_d = cfg_wdata_i;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          slot_d = slot_i;
          unique case (op_e'(op_i))
            OP_ROW, OP_EDGE: ;
            OP_COMPUTE: begin
              acc_d = '0;
              i_d   = '0;
              if (nc_q == '0) begin
                ov_d = 1'b1; kind_d = 1'b0; id_d = '0; deg_d = '0; oc_d = '0; err_d = 1'b1;
                state_d = ST_OUT;
              end else begin
                state_d = ST_SPAN0;
              end
            end
            OP_QUERY: begin
              if (32'(slot_i) >= 32'(nc_q)) begin
                ov_d = 1'b1; kind_d = 1'b1; id_d = NID_W'(slot_i); deg_d = '0;
                oc_d = '0; err_d = 1'b1;
                state_d = ST_OUT;
              end else begin
                state_d = ST_QRY0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_OUT: begin
        if (out_ready_i) begin
          ov_d = 1'b0;
          state_d = ST_IDLE;
        end
      end
      ST_QRY0: begin
        rs_raddr = NAW'(slot_q);
        state_d = ST_QRY1;
      end
      ST_QRY1: begin
        rs_raddr = NAW'(slot_q) + 1'b1;
        lo_d = clip_rd;
        oc_d = cf_rd_q;
        state_d = ST_QRY2;
      end
      ST_QRY2: begin
        if (clip_rd > lo_q) deg_w = clip_rd - lo_q;
        if (32'(deg_w) > 32'(DEG_MAX)) deg_d = DEG_MAX;
        else deg_d = NID_W'(deg_w);
        ov_d = 1'b1; kind_d = 1'b1; id_d = NID_W'(slot_q); err_d = 1'b0;
        state_d = ST_OUT;
      end
      ST_SPAN0: begin
        rs_raddr = NAW'(i_q);
        state_d = ST_SPAN1;
      end
      ST_SPAN1: begin
        rs_raddr = i_q + 1'b1;
        lo_d = clip_rd;
        state_d = ST_SPAN2;
      end
      ST_SPAN2: begin
        hi_d = (clip_rd < lo_q) ? lo_q : clip_rd;
        a_d = lo_q;
        str_d = '0;
        sum_d = '0;
        if ((hi_d - lo_q) < OW'(2)) begin
          coef_d = '0;
          state_d = ST_STORE;
        end else begin
          state_d = ST_ARD;
        end
      end
      ST_ARD: begin
        eg_raddr = EAW'(a_q);
        state_d = (a_q >= hi_q) ? ST_MUL : ST_AWT;
      end
      ST_AWT: begin
        wa_d = wt_rd_q;
        str_d = str_q + SW'(wt_rd_q);
        a_d = a_q + 1'b1;
        j_d = nb_rd_q;
        rs_raddr = NAW'(nb_rd_q);
        state_d = (32'(nb_rd_q) >= 32'(nc_q)) ? ST_ARD : ST_J1;
      end
      ST_J1: begin
        rs_raddr = NAW'(j_q) + 1'b1;
        b_d = clip_rd;
        state_d = ST_J2;
      end
      ST_J2: begin
        jhi_d = (clip_rd < b_q) ? b_q : clip_rd;
        state_d = ST_BRD;
      end
      ST_BRD: begin
        eg_raddr = EAW'(b_q);
        state_d = (b_q >= jhi_q) ? ST_ARD : ST_BWT;
      end
      ST_BWT: begin
        h_d = nb_rd_q;
        b_d = b_q + 1'b1;
        s_d = lo_q;
        state_d = (32'(nb_rd_q) == 32'(i_q)) ? ST_BRD : ST_SRD;
      end
      ST_SRD: begin
        eg_raddr = EAW'(s_q);
        state_d = (s_q >= hi_q) ? ST_BRD : ST_SWT;
      end
      ST_SWT: begin
        if (nb_rd_q == h_q) begin
          if (wt_rd_q != '0) sum_d = sum_q + SUMW'(wa_q) + SUMW'(wt_rd_q);
          state_d = ST_BRD;
        end else begin
          s_d = s_q + 1'b1;
          state_d = ST_SRD;
        end
      end
      ST_MUL: begin
        alu_req.start = 1'b1;
        alu_req.op = ALU_MUL;
        state_d = ST_MULW;
      end
      ST_MULW: begin
        alu_b = alu_res[DENW-1:0];
        if (!alu_busy) begin
          if (alu_res[DENW-1:0] == '0) begin
            coef_d = '0;
            state_d = ST_STORE;
          end else begin
            alu_req.start = 1'b1;
            alu_req.op = ALU_DIV;
            state_d = ST_DIVW;
          end
        end
      end
      ST_DIVW: begin
        if (!alu_busy) begin
          coef_d = (|alu_res[DVW-1:31]) ? Q31_ONE : alu_res[COEF_W-1:0];
          state_d = ST_STORE;
        end
      end
      ST_STORE: begin
        acc_d = acc_sum;
        i_d = i_q + 1'b1;
        alu_a = DVW'(acc_sum);
        alu_b = DENW'(nc_q);
        if (32'(i_d) == 32'(nc_q)) begin
          alu_req.start = 1'b1;
          alu_req.op = ALU_DIV;
          state_d = ST_AVGW;
        end else begin
          state_d = ST_SPAN0;
        end
      end
      ST_AVGW: begin
        if (!alu_busy) begin
          ov_d = 1'b1; kind_d = 1'b0; id_d = '0; deg_d = '0; err_d = 1'b0;
          oc_d = alu_res[COEF_W-1:0];
          state_d = ST_OUT;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      nc_q    <= '0;
      ov_q    <= 1'b0;
      acc_q   <= '0;
    end else begin
      state_q <= state_d;
      nc_q    <= nc_d;
      ov_q    <= ov_d;
      acc_q   <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d; lo_q <= lo_d; hi_q <= hi_d; a_q <= a_d; b_q <= b_d; jhi_q <= jhi_d;
    s_q <= s_d; j_q <= j_d; h_q <= h_d; slot_q <= slot_d; wa_q <= wa_d;
    str_q <= str_d; sum_q <= sum_d; coef_q <= coef_d;
    kind_q <= kind_d; err_q <= err_d; id_q <= id_d; deg_q <= deg_d; oc_q <= oc_d;
  end

  assign out_valid_o   = ov_q;
  assign result_kind_o = kind_q;
  assign node_id_o     = id_q;
  assign node_degree_o = deg_q;
  assign coefficient_o = oc_q;
  assign error_flag_o  = err_q;

  a_alu_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_req.start |-> !alu_busy) else $error("alu started while busy");
  a_coef_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cf_we |-> (coef_q <= Q31_ONE)) else $error("coefficient above one");
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ARD) |-> (a_q <= hi_q)) else $error("row scan past end");
  a_out_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && out_ready_i) |=> !ov_q) else $error("result word not dropped");

endmodule

FILE: verif/tb.sv
// Testbench for weighted_clustering_coefficient: directed table, random graphs, self-checking.
module tb;
  import wcc_pkg::*;

  typedef struct packed {
    logic        kind;
    logic [9:0]  nid;
    logic [9:0]  deg;
    logic [31:0] coef;
    logic        err;
  } res_t;

  typedef struct packed {
    op_e         op;
    logic [13:0] slot;
    logic [13:0] val;
    logic [31:0] wt;
    logic        typed;
    res_t        res;
  } stim_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [10:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  op_i = '0;
  logic [13:0] slot_i = '0;
  logic [13:0] entry_value_i = '0;
  logic [31:0] edge_weight_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        result_kind_o;
  logic [9:0]  node_id_o;
  logic [9:0]  node_degree_o;
  logic [31:0] coefficient_o;
  logic        error_flag_o;

  weighted_clustering_coefficient u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_ready_o,
    .op_i, .slot_i, .entry_value_i, .edge_weight_i, .out_valid_o, .out_ready_i,
    .result_kind_o, .node_id_o, .node_degree_o, .coefficient_o, .error_flag_o
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    #40_000_000;
    $display("** weighted_clustering_coefficient: FAILED **");
    $finish;
  end

  // graph mirror
  logic [13:0] row_start [0:1024];
  logic [13:0] nbr_id [0:8191];
  logic [31:0] nbr_wt [0:8191];
  logic [31:0] node_coef_q [0:1023];
  int unsigned node_cnt;

  res_t pending_q[$];
  bit   failed;
  bit   quiet;
  bit   hold_req;
  int   word_cnt;

  function automatic void row_bounds(int unsigned n, output int unsigned lo, output int unsigned hi);
    int unsigned a, b;
    if (n >= node_cnt) begin
      lo = 0;
      hi = 0;
      return;
    end
    a = row_start[n];
    b = row_start[n+1];
    if (a > 8192) a = 8192;
    if (b > 8192) b = 8192;
    if (b < a) b = a;
    lo = a;
    hi = b;
  endfunction

  function automatic logic [31:0] q31_ratio(longint unsigned num, longint unsigned den);
    longint unsigned q, r;
    q = num / den;
    r = num % den;
    if (q >= 2) return Q31_ONE;
    for (int b = 0; b < 30; b++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 1;
      end
    end
    if (q > 64'h8000_0000) q = 64'h8000_0000;
    return q[31:0];
  endfunction

  function automatic logic [31:0] clustering_of(int unsigned i);
    int unsigned lo, hi, jlo, jhi, k, h;
    longint unsigned tri_sum, strength, w;
    tri_sum = 0;
    strength = 0;
    row_bounds(i, lo, hi);
    k = hi - lo;
    if (k < 2) return '0;
    for (int unsigned a = lo; a < hi; a++) begin
      strength += nbr_wt[a];
      row_bounds(nbr_id[a], jlo, jhi);
      for (int unsigned b = jlo; b < jhi; b++) begin
        h = nbr_id[b];
        if (h == i) continue;
        w = 0;
        for (int unsigned s = lo; s < hi; s++) begin
          if (nbr_id[s] == h) begin
            w = nbr_wt[s];
            break;
          end
        end
        if (w != 0) tri_sum += longint'(nbr_wt[a]) + w;
      end
    end
    if (strength * (k - 1) == 0) return '0;
    return q31_ratio(tri_sum, strength * (k - 1));
  endfunction

  function automatic bit graph_word(stim_t s, output res_t r);
    longint unsigned acc;
    int unsigned lo, hi, d;
    r = '0;
    case (s.op)
      OP_ROW: begin
        if (s.slot <= 1024) row_start[s.slot] = s.val;
        return 0;
      end
      OP_EDGE: begin
        if (s.slot < 8192) begin
          nbr_id[s.slot] = s.val;
          nbr_wt[s.slot] = s.wt;
        end
        return 0;
      end
      OP_COMPUTE: begin
        acc = 0;
        for (int unsigned i = 0; i < node_cnt; i++) begin
          node_coef_q[i] = clustering_of(i);
          acc += node_coef_q[i];
        end
        r.err = (node_cnt == 0);
        if (node_cnt != 0) r.coef = 32'(acc / node_cnt);
        return 1;
      end
      default: begin
        r.kind = 1'b1;
        r.nid = s.slot[9:0];
        if (s.slot >= node_cnt) begin
          r.err = 1'b1;
        end else begin
          row_bounds(s.slot, lo, hi);
          d = hi - lo;
          r.deg = (d > 1023) ? 10'd1023 : d[9:0];
          r.coef = node_coef_q[s.slot];
        end
        return 1;
      end
    endcase
  endfunction

  task automatic send_word(stim_t s);
    res_t r;
    op_i = s.op;
    slot_i = s.slot;
    entry_value_i = s.val;
    edge_weight_i = s.wt;
    in_valid_i = 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (graph_word(s, r)) pending_q.push_back(s.typed ? s.res : r);
    word_cnt++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
    if (!quiet && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 14)) @(negedge clk_i);
  endtask

  task automatic send_op(op_e op, int unsigned slot, int unsigned val, logic [31:0] wt);
    stim_t s;
    s = '0;
    s.op = op;
    s.slot = slot[13:0];
    s.val = val[13:0];
    s.wt = wt;
    send_word(s);
  endtask

  task automatic set_node_count(int unsigned v);
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    cfg_wdata_i = v[10:0];
    cfg_we_i = 1'b1;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    node_cnt = (v[10:0] > 1024) ? 1024 : v[10:0];
  endtask

  function automatic logic [31:0] pick_weight();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom();
      default: return $urandom_range(1, 32'h0003_0000);
    endcase
  endfunction

  // receiver with random stalls and one long hold
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i = 1'b0;
        repeat (300) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready_i = 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk_i);
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    res_t got, want;
    if (out_valid_o && out_ready_i) begin
      got = '{result_kind_o, node_id_o, node_degree_o, coefficient_o, error_flag_o};
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        failed = 1'b1;
      end else begin
        want = pending_q.pop_front();
        if (got.kind !== want.kind)
          $display("%0t: result_kind exp %0d got %0d", $time, want.kind, got.kind);
        if (got.nid !== want.nid)
          $display("%0t: node_id exp %0d got %0d", $time, want.nid, got.nid);
        if (got.deg !== want.deg)
          $display("%0t: node_degree exp %0d got %0d", $time, want.deg, got.deg);
        if (got.coef !== want.coef)
          $display("%0t: coefficient exp %h got %h", $time, want.coef, got.coef);
        if (got.err !== want.err)
          $display("%0t: error_flag exp %0d got %0d", $time, want.err, got.err);
        if (got !== want) failed = 1'b1;
      end
    end
  end

  stim_t empty_tab[] = '{
    '{OP_COMPUTE, 14'd0,     14'd0, 32'd0, 1'b1, '{1'b0, 10'd0,    10'd0, 32'd0, 1'b1}},
    '{OP_QUERY,   14'd0,     14'd0, 32'd0, 1'b1, '{1'b1, 10'd0,    10'd0, 32'd0, 1'b1}},
    '{OP_QUERY,   14'd16383, 14'd0, 32'd0, 1'b1, '{1'b1, 10'd1023, 10'd0, 32'd0, 1'b1}},
    '{OP_ROW,     14'd16383, 14'd5, 32'd0, 1'b0, '0},
    '{OP_EDGE,    14'd16383, 14'd5, 32'd7, 1'b0, '0}
  };

  stim_t full_tab[] = '{
    '{OP_QUERY,   14'd2047, 14'd0, 32'd0, 1'b1, '{1'b1, 10'd1023, 10'd0, 32'd0, 1'b1}},
    '{OP_QUERY,   14'd1024, 14'd0, 32'd0, 1'b1, '{1'b1, 10'd0,    10'd0, 32'd0, 1'b1}}
  };

  // node0 clipped, node4 inverted, foreign and duplicate neighbors, max weights
  stim_t graph_tab[] = '{
    '{OP_EDGE, 14'd0,    14'd2,     32'h0001_0000, 1'b0, '0},
    '{OP_EDGE, 14'd1,    14'd16383, 32'h0002_0000, 1'b0, '0},
    '{OP_EDGE, 14'd2,    14'd1,     32'h0001_0000, 1'b0, '0},
    '{OP_EDGE, 14'd3,    14'd3,     32'hFFFF_FFFF, 1'b0, '0},
    '{OP_EDGE, 14'd4,    14'd1,     32'h0002_0000, 1'b0, '0},
    '{OP_EDGE, 14'd5,    14'd2,     32'hFFFF_FFFF, 1'b0, '0},
    '{OP_EDGE, 14'd6,    14'd2,     32'h0000_5000, 1'b0, '0},
    '{OP_EDGE, 14'd8191, 14'd0,     32'h0000_0000, 1'b0, '0},
    '{OP_ROW,  14'd0,    14'd16383, 32'd0, 1'b0, '0},
    '{OP_ROW,  14'd1,    14'd0,     32'd0, 1'b0, '0},
    '{OP_ROW,  14'd2,    14'd2,     32'd0, 1'b0, '0},
    '{OP_ROW,  14'd3,    14'd4,     32'd0, 1'b0, '0},
    '{OP_ROW,  14'd4,    14'd7,     32'd0, 1'b0, '0},
    '{OP_ROW,  14'd5,    14'd3,     32'd0, 1'b0, '0},
    '{OP_ROW,  14'd1024, 14'd0,     32'd0, 1'b0, '0}
  };

  initial begin
    int n, e, pos;
    int unsigned starts[$];
    failed = 1'b0;
    quiet = 1'b0;
    hold_req = 1'b0;
    word_cnt = 0;
    node_cnt = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    set_node_count(0);
    foreach (empty_tab[k]) send_word(empty_tab[k]);
    for (int r = 0; r <= 16; r++) send_op(OP_ROW, r, 0, 0);
    set_node_count(2047);
    foreach (full_tab[k]) send_word(full_tab[k]);
    foreach (graph_tab[k]) send_word(graph_tab[k]);
    set_node_count(5);
    send_op(OP_COMPUTE, 0, 0, 0);
    for (int q = 0; q <= 5; q++) send_op(OP_QUERY, q, 0, 0);
    word_cnt = 0;

    for (int ph = 0; word_cnt < 360; ph++) begin
      quiet = (word_cnt > 300);
      n = $urandom_range(2, 10);
      e = $urandom_range(n, 3 * n);
      for (int s = 0; s < e; s++)
        send_op(OP_EDGE, s, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 16383)
                                                       : $urandom_range(0, n - 1),
                pick_weight());
      starts.delete();
      for (int r = 0; r <= n; r++) starts.push_back($urandom_range(0, e));
      if ($urandom_range(0, 3) != 0) starts.sort();
      for (int r = 0; r <= n; r++) send_op(OP_ROW, r, starts[r], 0);
      if ($urandom_range(0, 2) == 0)
        send_op(OP_ROW, $urandom_range(1025, 16383), $urandom_range(0, 16383), 0);
      if ($urandom_range(0, 2) == 0)
        send_op(OP_EDGE, $urandom_range(8192, 16383), $urandom_range(0, 16383), $urandom());
      case ($urandom_range(0, 7))
        0: set_node_count($urandom_range(n, 16));
        1: set_node_count(0);
        default: set_node_count(n);
      endcase
      send_op(OP_COMPUTE, 0, 0, 0);
      if (ph == 3) begin
        while (pending_q.size() != 0) @(negedge clk_i);
        hold_req = 1'b1;
        repeat (12) send_op(OP_QUERY, $urandom_range(0, n), 0, 0);
      end
      pos = $urandom_range(0, e - 1);
      send_op(OP_EDGE, pos, nbr_id[pos], pick_weight());
      repeat ($urandom_range(2, 6))
        send_op(OP_QUERY, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16383)
                                                      : $urandom_range(0, n), 0, 0);
    end

    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    if (!failed && pending_q.size() == 0) begin
      $display("** weighted_clustering_coefficient: PASSED **");
    end else begin
      $display("** weighted_clustering_coefficient: FAILED **");
    end
    $finish;
  end

endmodule
